// ===== sv/symbol_hash_table_probe_assert.svh =====
// ----------------------------------------------------------------------------
// Symbol hash table probe assertion macros
// Shorthand for the concurrent checks of the probe engine.
// ----------------------------------------------------------------------------
`ifndef SYMBOL_HASH_TABLE_PROBE_ASSERT_SVH
`define SYMBOL_HASH_TABLE_PROBE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SHTP_ASSERT_IMP(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define SHTP_ASSERT_NXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== sv/shtp_pkg.sv =====
// ----------------------------------------------------------------------------
// Symbol hash table probe package
// Shared constants, opcodes and entry attribute type.
// ----------------------------------------------------------------------------
`default_nettype none

package shtp_pkg;

   localparam int TABLE_SLOTS_DFLT = 256;
   localparam int NAME_CHARS_DFLT  = 8;

   localparam int OPCODE_W = 2;
   localparam int NAME_W   = 64;
   localparam int SLOT_W   = 8;
   localparam int CLASS_W  = 4;
   localparam int OFFSET_W = 32;
   localparam int DIM_W    = 16;

   localparam logic [7:0]         CHAR_MASK = 8'o177;
   localparam logic [CLASS_W-1:0] KW_CLASS_RESET = 4'd1;

   typedef enum logic [OPCODE_W-1:0] {
      OP_LOOKUP = 2'd0,
      OP_WRITE  = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_NOP    = 2'd3
   } opcode_type;

   typedef struct packed {
      logic [CLASS_W-1:0]         cls;
      logic signed [OFFSET_W-1:0] offset;
      logic [DIM_W-1:0]           dim;
   } attr_type;

   localparam int ATTR_W = $bits(attr_type);

endpackage

`default_nettype wire

// ===== sv/symbol_hash_table_probe.sv =====
// Lookup: the name is hashed, then slots are probed, one per cycle, up to the result.
// Attribute write: ST_WR_RD, then ST_WR_OUT. End-block clear: one slot per cycle
// through the memory read port, then ST_CLR_TAIL. One request is in flight at a time;
// the next is taken in the cycle after the result is registered.
// After reset a clearing pass over every slot zeroes both memories
// while req_ready stays low; csr writes are taken throughout.
// ----------------------------------------------------------------------------
// Symbol hash table probe
// Open-addressed symbol table with linear probing, attribute writes and
// end-block clears, held in two single-port-read memories.
// ----------------------------------------------------------------------------
`default_nettype none
`include "symbol_hash_table_probe_assert.svh"

module symbol_hash_table_probe #(
   parameter int TABLE_SLOTS = shtp_pkg::TABLE_SLOTS_DFLT,
   parameter int NAME_CHARS  = shtp_pkg::NAME_CHARS_DFLT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_valid,
   output      logic                                 csr_ready,
   input  wire logic [shtp_pkg::CLASS_W-1:0]         csr_keyword_class,
   input  wire logic                                 req_valid,
   output      logic                                 req_ready,
   input  wire logic [shtp_pkg::OPCODE_W-1:0]        req_opcode,
   input  wire logic [shtp_pkg::NAME_W-1:0]          req_name_chars,
   input  wire logic [shtp_pkg::SLOT_W-1:0]          req_slot_in,
   input  wire logic [shtp_pkg::CLASS_W-1:0]         req_class_in,
   input  wire logic signed [shtp_pkg::OFFSET_W-1:0] req_offset_in,
   input  wire logic [shtp_pkg::DIM_W-1:0]           req_dim_in,
   output      logic                                 rsp_valid,
   input  wire logic                                 rsp_ready,
   output      logic [shtp_pkg::SLOT_W-1:0]          rsp_slot_out,
   output      logic                                 rsp_found,
   output      logic [shtp_pkg::CLASS_W-1:0]         rsp_class_out,
   output      logic signed [shtp_pkg::OFFSET_W-1:0] rsp_offset_out,
   output      logic [shtp_pkg::DIM_W-1:0]           rsp_dim_out,
   output      logic                                 rsp_overflow
);

   import shtp_pkg::*;

   localparam int               TSLOT_W   = $clog2(TABLE_SLOTS);
   localparam int               TNAME_W   = 8 * NAME_CHARS;
   localparam logic [TSLOT_W-1:0] LAST_SLOT = TSLOT_W'(TABLE_SLOTS - 1);

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_HASH,
      ST_PROBE,
      ST_WR_RD,
      ST_WR_OUT,
      ST_CLEAR,
      ST_CLR_TAIL,
      ST_EMIT
   } state_type;

   state_type           state_ff, state_in;
   logic [TSLOT_W-1:0]  idx_ff, idx_in;
   logic [TSLOT_W-1:0]  cnt_ff, cnt_in;
   logic [TSLOT_W-1:0]  addr_ff, addr_in;
   logic                chk_vld_ff, chk_vld_in;
   logic [TSLOT_W-1:0]  chk_addr_ff, chk_addr_in;
   logic [CLASS_W-1:0]  kw_ff, kw_in;
   opcode_type          op_ff, op_in;
   logic [TNAME_W-1:0]  name_ff, name_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   attr_type            attr_req_ff, attr_req_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic                rsp_found_ff, rsp_found_in;
   attr_type            rsp_attr_ff, rsp_attr_in;
   logic                rsp_ovf_ff, rsp_ovf_in;

   logic                accept;
   logic                out_free;
   logic                hash_load;
   logic [TSLOT_W-1:0]  home;
   logic [TSLOT_W-1:0]  nxt_addr;

   logic                rd_en;
   logic [TSLOT_W-1:0]  rd_addr;
   logic [TSLOT_W-1:0]  wr_addr;
   logic                names_we;
   logic [TNAME_W-1:0]  names_wdata;
   logic [TNAME_W-1:0]  names_rd;
   logic                attr_we;
   attr_type            attr_wdata;
   logic [ATTR_W-1:0]   attr_rd_raw;
   attr_type            attr_rd;

   logic                slot_empty;
   logic                slot_match;

   shtp_hash #(
      .TABLE_SLOTS (TABLE_SLOTS),
      .NAME_CHARS  (NAME_CHARS)
   ) u_hash (
      .clock (clock),
      .load  (hash_load),
      .name  (req_name_chars[TNAME_W-1:0]),
      .home  (home)
   );

   shtp_ram #(
      .WIDTH (TNAME_W),
      .DEPTH (TABLE_SLOTS)
   ) u_names_ram (
      .clock   (clock),
      .wr_en   (names_we),
      .wr_addr (wr_addr),
      .wr_data (names_wdata),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (names_rd)
   );

   shtp_ram #(
      .WIDTH (ATTR_W),
      .DEPTH (TABLE_SLOTS)
   ) u_attr_ram (
      .clock   (clock),
      .wr_en   (attr_we),
      .wr_addr (wr_addr),
      .wr_data (attr_wdata),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (attr_rd_raw)
   );

   assign attr_rd    = attr_type'(attr_rd_raw);
   assign slot_empty = (names_rd[7:0] == 8'd0);
   assign slot_match = (names_rd == name_ff);
   assign nxt_addr   = (addr_ff == LAST_SLOT) ? '0 : addr_ff + 1'b1;
   assign accept     = req_valid && (state_ff == ST_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      addr_in      = addr_ff;
      chk_vld_in   = 1'b0;
      chk_addr_in  = idx_ff;
      kw_in        = csr_valid ? csr_keyword_class : kw_ff;
      op_in        = op_ff;
      name_in      = name_ff;
      slot_in      = slot_ff;
      attr_req_in  = attr_req_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_slot_in  = rsp_slot_ff;
      rsp_found_in = rsp_found_ff;
      rsp_attr_in  = rsp_attr_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      hash_load    = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = '0;
      wr_addr      = '0;
      names_we     = 1'b0;
      names_wdata  = '0;
      attr_we      = 1'b0;
      attr_wdata   = '0;

      // Clear sweep write-back: in the cycle after the attribute read is issued.
      if (chk_vld_ff && (attr_rd.cls != kw_ff)) begin
         names_we = 1'b1;
         wr_addr  = chk_addr_ff;
      end

      case (state_ff)
         ST_INIT: begin
            names_we = 1'b1;
            attr_we  = 1'b1;
            wr_addr  = idx_ff;
            if (idx_ff == LAST_SLOT) begin
               idx_in   = '0;
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               hash_load   = 1'b1;
               op_in       = opcode_type'(req_opcode);
               name_in     = req_name_chars[TNAME_W-1:0];
               slot_in     = req_slot_in;
               attr_req_in = '{cls: req_class_in, offset: req_offset_in, dim: req_dim_in};
               case (opcode_type'(req_opcode))
                  OP_LOOKUP: begin
                     state_in = (req_name_chars[7:0] == 8'd0) ? ST_EMIT : ST_HASH;
                  end
                  OP_WRITE: begin
                     state_in = (int'(req_slot_in) < TABLE_SLOTS) ? ST_WR_RD : ST_EMIT;
                  end
                  OP_CLEAR: begin
                     idx_in   = '0;
                     state_in = ST_CLEAR;
                  end
                  default: begin
                     state_in = ST_EMIT;
                  end
               endcase
            end
         end
         ST_HASH: begin
            rd_en    = 1'b1;
            rd_addr  = home;
            addr_in  = home;
            cnt_in   = '0;
            state_in = ST_PROBE;
         end
         ST_PROBE: begin
            if (slot_empty) begin
               if (out_free) begin
                  names_we     = 1'b1;
                  names_wdata  = name_ff;
                  attr_we      = 1'b1;
                  wr_addr      = addr_ff;
                  rsp_valid_in = 1'b1;
                  rsp_slot_in  = SLOT_W'(addr_ff);
                  rsp_found_in = 1'b0;
                  rsp_attr_in  = '0;
                  rsp_ovf_in   = 1'b0;
                  state_in     = ST_IDLE;
               end
            end else if (slot_match) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_slot_in  = SLOT_W'(addr_ff);
                  rsp_found_in = 1'b1;
                  rsp_attr_in  = attr_rd;
                  rsp_ovf_in   = 1'b0;
                  state_in     = ST_IDLE;
               end
            end else if (cnt_ff == LAST_SLOT) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_slot_in  = '0;
                  rsp_found_in = 1'b0;
                  rsp_attr_in  = '0;
                  rsp_ovf_in   = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               rd_en   = 1'b1;
               rd_addr = nxt_addr;
               addr_in = nxt_addr;
               cnt_in  = cnt_ff + 1'b1;
            end
         end
         ST_WR_RD: begin
            rd_en      = 1'b1;
            rd_addr    = TSLOT_W'(slot_ff);
            attr_we    = 1'b1;
            wr_addr    = TSLOT_W'(slot_ff);
            attr_wdata = attr_req_ff;
            state_in   = ST_WR_OUT;
         end
         ST_WR_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_slot_in  = slot_ff;
               rsp_found_in = !slot_empty;
               rsp_attr_in  = attr_req_ff;
               rsp_ovf_in   = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         ST_CLEAR: begin
            rd_en       = 1'b1;
            rd_addr     = idx_ff;
            chk_vld_in  = 1'b1;
            chk_addr_in = idx_ff;
            if (idx_ff == LAST_SLOT) begin
               idx_in   = '0;
               state_in = ST_CLR_TAIL;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_CLR_TAIL: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_slot_in  = '0;
               rsp_found_in = 1'b0;
               rsp_attr_in  = '0;
               rsp_ovf_in   = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_slot_in  = (op_ff == OP_WRITE) ? slot_ff : '0;
               rsp_found_in = 1'b0;
               rsp_attr_in  = '0;
               rsp_ovf_in   = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      name_ff      <= name_in;
      slot_ff      <= slot_in;
      attr_req_ff  <= attr_req_in;
      addr_ff      <= addr_in;
      cnt_ff       <= cnt_in;
      chk_addr_ff  <= chk_addr_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_found_ff <= rsp_found_in;
      rsp_attr_ff  <= rsp_attr_in;
      rsp_ovf_ff   <= rsp_ovf_in;
      if (reset) begin
         state_ff     <= ST_INIT;
         idx_ff       <= '0;
         chk_vld_ff   <= 1'b0;
         kw_ff        <= KW_CLASS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         chk_vld_ff   <= chk_vld_in;
         kw_ff        <= kw_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign csr_ready      = 1'b1;
   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_slot_out   = rsp_slot_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_class_out  = rsp_attr_ff.cls;
   assign rsp_offset_out = rsp_attr_ff.offset;
   assign rsp_dim_out    = rsp_attr_ff.dim;
   assign rsp_overflow   = rsp_ovf_ff;

   `SHTP_ASSERT_IMP(a_insert_only_empty, clock, reset,
      (state_ff == ST_PROBE) && names_we, slot_empty,
      "probe wrote a name over an occupied slot")
   `SHTP_ASSERT_NXT(a_accept_busy, clock, reset, accept, !req_ready,
      "request accepted without leaving idle")
   `SHTP_ASSERT_IMP(a_rsp_from_work, clock, reset,
      $rose(rsp_valid_ff), $past(state_ff != ST_IDLE),
      "response raised without a request in progress")

endmodule

`default_nettype wire

// ===== sv/shtp_ram.sv =====
// ----------------------------------------------------------------------------
// Symbol hash table probe RAM
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module shtp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/shtp_hash.sv =====
// ----------------------------------------------------------------------------
// Symbol hash table probe hash unit
// Registers the sum of the 7-bit name characters and reduces it to a home
// slot with a constant restoring remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module shtp_hash #(
   parameter int TABLE_SLOTS = shtp_pkg::TABLE_SLOTS_DFLT,
   parameter int NAME_CHARS  = shtp_pkg::NAME_CHARS_DFLT
) (
   input  wire logic                           clock,
   input  wire logic                           load,
   input  wire logic [8*NAME_CHARS-1:0]        name,
   output      logic [$clog2(TABLE_SLOTS)-1:0] home
);

   import shtp_pkg::*;

   localparam int HSLOT_W = $clog2(TABLE_SLOTS);
   localparam int MAX_SUM = NAME_CHARS * 127;
   localparam int SUM_W   = $clog2(MAX_SUM + 1);

   logic [SUM_W-1:0] sum_ff;
   logic [SUM_W-1:0] sum_in;
   logic [SUM_W-1:0] rem;

   always_comb begin
      sum_in = '0;
      for (int i = 0; i < NAME_CHARS; i++) begin
         sum_in = sum_in + SUM_W'(name[8*i +: 8] & CHAR_MASK);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         sum_ff <= sum_in;
      end
   end

   always_comb begin
      rem = sum_ff;
      for (int j = SUM_W - 1; j >= 0; j--) begin
         if (((TABLE_SLOTS << j) <= MAX_SUM) && (rem >= SUM_W'(TABLE_SLOTS << j))) begin
            rem = rem - SUM_W'(TABLE_SLOTS << j);
         end
      end
   end

   assign home = HSLOT_W'(rem);

endmodule

`default_nettype wire

// ===== tb/symbol_hash_table_probe_test.sv =====
// ----------------------------------------------------------------------------
// Symbol hash table probe testbench
// Drives lookups, attribute writes and end-block clears into the probe engine
// with random gaps and result stalls. A table model in the bench predicts
// every result, which is then compared field by field with what comes out.
// The run also fills the table until lookups report overflow.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module symbol_hash_table_probe_test;

   import shtp_pkg::*;

   localparam int TABLE_SLOTS = TABLE_SLOTS_DFLT;
   localparam int POOL_SIZE   = 24;

   typedef struct packed {
      opcode_type                op;
      logic [NAME_W-1:0]         name;
      logic [SLOT_W-1:0]         slot;
      logic [CLASS_W-1:0]        cls;
      logic signed [OFFSET_W-1:0] offset;
      logic [DIM_W-1:0]          dim;
   } table_request_type;

   typedef struct packed {
      logic [SLOT_W-1:0]          slot;
      logic                       found;
      logic [CLASS_W-1:0]         cls;
      logic signed [OFFSET_W-1:0] offset;
      logic [DIM_W-1:0]           dim;
      logic                       overflow;
   } probe_result_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CLASS_W-1:0]         csr_keyword_class = KW_CLASS_RESET;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [OPCODE_W-1:0]        req_opcode = OP_NOP;
   logic [NAME_W-1:0]          req_name_chars = '0;
   logic [SLOT_W-1:0]          req_slot_in = '0;
   logic [CLASS_W-1:0]         req_class_in = '0;
   logic signed [OFFSET_W-1:0] req_offset_in = '0;
   logic [DIM_W-1:0]           req_dim_in = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [SLOT_W-1:0]          rsp_slot_out;
   logic                       rsp_found;
   logic [CLASS_W-1:0]         rsp_class_out;
   logic signed [OFFSET_W-1:0] rsp_offset_out;
   logic [DIM_W-1:0]           rsp_dim_out;
   logic                       rsp_overflow;

   logic [NAME_W-1:0]          sym_name[TABLE_SLOTS];
   logic [CLASS_W-1:0]         sym_class[TABLE_SLOTS];
   logic signed [OFFSET_W-1:0] sym_offset[TABLE_SLOTS];
   logic [DIM_W-1:0]           sym_dim[TABLE_SLOTS];
   logic [CLASS_W-1:0]         keep_class = KW_CLASS_RESET;

   table_request_type request_backlog[$];
   probe_result_type  awaited_outcomes[$];
   table_request_type req_now;
   logic [NAME_W-1:0] name_pool[POOL_SIZE];

   logic sender_idle = 1'b0;
   logic receiver_idle = 1'b0;
   int   send_wait = 0;
   int   hold_left = 0;
   int   error_count = 0;
   int   accepted_count = 0;
   int   setting_count = 0;
   int   insert_count = 0;
   int   hit_count = 0;
   int   full_count = 0;
   int   write_count = 0;
   int   clear_count = 0;
   int   null_count = 0;

   symbol_hash_table_probe i_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_keyword_class (csr_keyword_class),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_name_chars    (req_name_chars),
      .req_slot_in       (req_slot_in),
      .req_class_in      (req_class_in),
      .req_offset_in     (req_offset_in),
      .req_dim_in        (req_dim_in),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_slot_out      (rsp_slot_out),
      .rsp_found         (rsp_found),
      .rsp_class_out     (rsp_class_out),
      .rsp_offset_out    (rsp_offset_out),
      .rsp_dim_out       (rsp_dim_out),
      .rsp_overflow      (rsp_overflow)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int home_slot(input logic [NAME_W-1:0] name);
      int sum;
      sum = 0;
      for (int i = 0; i < NAME_CHARS_DFLT; i++) begin
         sum += int'(name[8*i +: 8] & CHAR_MASK);
      end
      return sum % TABLE_SLOTS;
   endfunction

   function automatic probe_result_type entry_view(input int s, input logic hit);
      probe_result_type res;
      res          = '0;
      res.slot     = SLOT_W'(s);
      res.found    = hit;
      res.cls      = sym_class[s];
      res.offset   = sym_offset[s];
      res.dim      = sym_dim[s];
      return res;
   endfunction

   // Updates the table model for one request and returns the result it gives.
   function automatic probe_result_type symbol_table_outcome(input table_request_type r);
      probe_result_type res;
      int               s;
      res = '0;
      case (r.op)
         OP_LOOKUP: begin
            if (r.name[7:0] == 8'h00) begin
               null_count++;
            end else begin
               s = home_slot(r.name);
               res.overflow = 1'b1;
               for (int n = 0; n < TABLE_SLOTS && res.overflow; n++) begin
                  if (sym_name[s][7:0] == 8'h00) begin
                     sym_name[s]   = r.name;
                     sym_class[s]  = '0;
                     sym_offset[s] = '0;
                     sym_dim[s]    = '0;
                     res = entry_view(s, 1'b0);
                     insert_count++;
                  end else if (sym_name[s] == r.name) begin
                     res = entry_view(s, 1'b1);
                     hit_count++;
                  end else begin
                     s = (s + 1) % TABLE_SLOTS;
                  end
               end
               if (res.overflow) begin
                  full_count++;
               end
            end
         end
         OP_WRITE: begin
            write_count++;
            if (int'(r.slot) >= TABLE_SLOTS) begin
               res.slot = r.slot;
            end else begin
               s = int'(r.slot);
               sym_class[s]  = r.cls;
               sym_offset[s] = r.offset;
               sym_dim[s]    = r.dim;
               res = entry_view(s, sym_name[s][7:0] != 8'h00);
            end
         end
         OP_CLEAR: begin
            clear_count++;
            for (int k = 0; k < TABLE_SLOTS; k++) begin
               if (sym_class[k] != keep_class) begin
                  sym_name[k] = '0;
               end
            end
         end
         default: begin
            null_count++;
         end
      endcase
      return res;
   endfunction

   function automatic table_request_type make_request(input opcode_type op,
                                                      input logic [NAME_W-1:0] name,
                                                      input logic [SLOT_W-1:0] slot,
                                                      input logic [CLASS_W-1:0] cls,
                                                      input logic [OFFSET_W-1:0] offset,
                                                      input logic [DIM_W-1:0] dim);
      table_request_type r;
      r.op     = op;
      r.name   = name;
      r.slot   = slot;
      r.cls    = cls;
      r.offset = offset;
      r.dim    = dim;
      return r;
   endfunction

   function automatic logic [NAME_W-1:0] random_name();
      logic [NAME_W-1:0] n;
      int                len;
      n = '0;
      if ($urandom_range(0, 5) == 0) begin
         return {$urandom, $urandom};
      end
      len = $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
         n[8*i +: 8] = 8'($urandom_range(1, 255));
      end
      return n;
   endfunction

   function automatic table_request_type random_request();
      table_request_type r;
      int                pick;
      logic [NAME_W-1:0] base;
      pick = $urandom_range(0, 99);
      base = name_pool[$urandom_range(0, POOL_SIZE - 1)];
      r = make_request(OP_LOOKUP, base, SLOT_W'($urandom), CLASS_W'($urandom),
                       OFFSET_W'($urandom), DIM_W'($urandom));
      if (pick < 55) begin
         if ($urandom_range(0, 6) == 0) begin
            r.name = random_name();
         end
      end else if (pick < 85) begin
         r.op = OP_WRITE;
         if ($urandom_range(0, 3) != 0) begin
            r.slot = SLOT_W'((home_slot(base) + $urandom_range(0, 2)) % TABLE_SLOTS);
         end
         if ($urandom_range(0, 4) < 2) begin
            r.cls = keep_class;
         end
      end else if (pick < 94) begin
         r.op = OP_CLEAR;
      end else if (pick < 97) begin
         r.name[7:0] = 8'h00;
      end else begin
         r.op = OP_NOP;
      end
      return r;
   endfunction

   task automatic compare_field(input string field, input logic [63:0] want,
                                input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, field, want, got);
         error_count++;
      end
   endtask

   task automatic wait_until_drained();
      do begin
         @(negedge clock);
      end while (request_backlog.size() != 0 || req_valid || awaited_outcomes.size() != 0);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_wait = 0;
      end else begin
         if (req_valid && req_ready) begin
            awaited_outcomes.push_back(symbol_table_outcome(req_now));
            accepted_count++;
            send_wait = sender_idle ? $urandom_range(0, 15) : 0;
         end
         if (!req_valid || req_ready) begin
            if (send_wait != 0) begin
               send_wait--;
               req_valid <= 1'b0;
            end else if (request_backlog.size() != 0) begin
               req_now = request_backlog.pop_front();
               req_valid      <= 1'b1;
               req_opcode     <= req_now.op;
               req_name_chars <= req_now.name;
               req_slot_in    <= req_now.slot;
               req_class_in   <= req_now.cls;
               req_offset_in  <= req_now.offset;
               req_dim_in     <= req_now.dim;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      probe_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_outcomes.size() == 0) begin
               $display("%0t: unexpected result: expected none, actual slot 0x%0h found %0b",
                        $time, rsp_slot_out, rsp_found);
               error_count++;
            end else begin
               want = awaited_outcomes.pop_front();
               compare_field("slot", 64'(want.slot), 64'(rsp_slot_out));
               compare_field("found", 64'(want.found), 64'(rsp_found));
               compare_field("class", 64'(want.cls), 64'(rsp_class_out));
               compare_field("offset", 64'(unsigned'(want.offset)),
                             64'(unsigned'(rsp_offset_out)));
               compare_field("dim", 64'(want.dim), 64'(rsp_dim_out));
               compare_field("overflow", 64'(want.overflow), 64'(rsp_overflow));
            end
            hold_left = receiver_idle ? $urandom_range(0, 15) : 0;
         end else if (rsp_valid && hold_left != 0) begin
            hold_left--;
         end
         rsp_ready <= (hold_left == 0);
      end
   end

   initial begin
      logic [CLASS_W-1:0] next_class;
      for (int k = 0; k < TABLE_SLOTS; k++) begin
         sym_name[k]   = '0;
         sym_class[k]  = '0;
         sym_offset[k] = '0;
         sym_dim[k]    = '0;
      end

      request_backlog.push_back(make_request(OP_NOP, {$urandom, $urandom}, 8'hFF, 4'hF,
                                             32'hFFFF_FFFF, 16'hFFFF));
      request_backlog.push_back(make_request(OP_LOOKUP, 64'hFF00, 8'h00, 4'h0, 32'h0, 16'h0));
      request_backlog.push_back(make_request(OP_LOOKUP, 64'h61, 8'h00, 4'h0, 32'h0, 16'h0));
      request_backlog.push_back(make_request(OP_LOOKUP, 64'h61, 8'h00, 4'h0, 32'h0, 16'h0));
      request_backlog.push_back(make_request(OP_LOOKUP, 64'hE1, 8'h00, 4'h0, 32'h0, 16'h0));
      request_backlog.push_back(make_request(OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 4'hF,
                                             32'hFFFF_FFFF, 16'hFFFF));
      request_backlog.push_back(make_request(OP_LOOKUP, 64'h01_7F7F, 8'h00, 4'h0, 32'h0, 16'h0));
      request_backlog.push_back(make_request(OP_LOOKUP, 64'h7F_017F, 8'h00, 4'h0, 32'h0, 16'h0));
      request_backlog.push_back(make_request(OP_LOOKUP, 64'h7F_017F, 8'h00, 4'h0, 32'h0, 16'h0));
      request_backlog.push_back(make_request(OP_WRITE, 64'h0, 8'd97, 4'hF, 32'h8000_0000,
                                             16'hFFFF));
      request_backlog.push_back(make_request(OP_WRITE, 64'hFFFF_FFFF_FFFF_FFFF, 8'd0, 4'h1,
                                             32'h7FFF_FFFF, 16'h0000));
      request_backlog.push_back(make_request(OP_LOOKUP, 64'h61, 8'h00, 4'h0, 32'h0, 16'h0));
      request_backlog.push_back(make_request(OP_WRITE, 64'h0, 8'd10, 4'h7, 32'd12345, 16'd99));
      request_backlog.push_back(make_request(OP_WRITE, 64'h0, 8'd255, 4'h0, 32'hFFFF_FFFF,
                                             16'd1));
      request_backlog.push_back(make_request(OP_LOOKUP, 64'h0A, 8'h00, 4'h0, 32'h0, 16'h0));
      request_backlog.push_back(make_request(OP_LOOKUP, 64'h0A, 8'h00, 4'h0, 32'h0, 16'h0));
      request_backlog.push_back(make_request(OP_CLEAR, 64'h0, 8'h00, 4'h0, 32'h0, 16'h0));
      request_backlog.push_back(make_request(OP_LOOKUP, 64'h7F_017F, 8'h00, 4'h0, 32'h0, 16'h0));
      request_backlog.push_back(make_request(OP_LOOKUP, 64'h61, 8'h00, 4'h0, 32'h0, 16'h0));
      request_backlog.push_back(make_request(OP_WRITE, 64'h0, 8'd0, 4'h2, 32'h0, 16'h0));
      request_backlog.push_back(make_request(OP_CLEAR, {$urandom, $urandom}, 8'hFF, 4'hF,
                                             32'hFFFF_FFFF, 16'hFFFF));
      request_backlog.push_back(make_request(OP_LOOKUP, 64'h7F_017F, 8'h00, 4'h0, 32'h0, 16'h0));
      request_backlog.push_back(make_request(OP_NOP, 64'h0, 8'h00, 4'h0, 32'h0, 16'h0));

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      wait_until_drained();

      for (int ph = 0; ph < 7; ph++) begin
         if (ph == 0) begin
            next_class = 4'hF;
         end else if (ph == 2) begin
            next_class = 4'h0;
         end else begin
            next_class = CLASS_W'($urandom_range(0, 15));
         end
         @(posedge clock);
         csr_keyword_class <= next_class;
         csr_valid         <= 1'b1;
         do begin
            @(posedge clock);
         end while (!csr_ready);
         csr_valid <= 1'b0;
         keep_class = next_class;
         setting_count++;

         @(negedge clock);
         sender_idle   = ph[0];
         receiver_idle = ph[1];
         if (ph == 2) begin
            // Fill the table past its capacity so that later lookups overflow.
            request_backlog.push_back(make_request(OP_CLEAR, 64'h0, 8'h00, 4'h0, 32'h0, 16'h0));
            for (int i = 0; i < TABLE_SLOTS + 14; i++) begin
               logic [NAME_W-1:0] fresh;
               fresh = {8'h00, $urandom, 8'(1 + (i >> 8)), 8'(i), 8'h5A};
               if (i < POOL_SIZE) begin
                  name_pool[i] = fresh;
               end
               request_backlog.push_back(make_request(OP_LOOKUP, fresh, SLOT_W'($urandom),
                                                      CLASS_W'($urandom), OFFSET_W'($urandom),
                                                      DIM_W'($urandom)));
            end
            for (int i = 0; i < 6; i++) begin
               request_backlog.push_back(make_request(OP_LOOKUP,
                                                      name_pool[$urandom_range(0, POOL_SIZE - 1)],
                                                      8'h00, 4'h0, 32'h0, 16'h0));
               request_backlog.push_back(make_request(OP_LOOKUP, random_name() | 64'h1,
                                                      8'h00, 4'h0, 32'h0, 16'h0));
            end
            for (int i = 0; i < 8; i++) begin
               request_backlog.push_back(make_request(OP_WRITE, 64'h0, SLOT_W'($urandom),
                                                      CLASS_W'($urandom), OFFSET_W'($urandom),
                                                      DIM_W'($urandom)));
            end
         end else begin
            for (int k = 0; k < POOL_SIZE; k++) begin
               name_pool[k] = random_name();
            end
            for (int i = 0; i < 100; i++) begin
               request_backlog.push_back(random_request());
            end
         end
         wait_until_drained();
      end

      repeat (300) @(posedge clock);
      $display("Covered %0d requests under %0d keyword-class settings: %0d inserts, %0d hits,",
               accepted_count, setting_count, insert_count, hit_count);
      $display("%0d table-full lookups, %0d attribute writes, %0d end-block clears, %0d nulls.",
               full_count, write_count, clear_count, null_count);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #50_000_000;
      $display("Timeout with %0d results outstanding.", awaited_outcomes.size());
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
